@@ design/csrpw_pkg.sv @@
package csrpw_pkg;

    // register widths
    localparam int ORG_W   = 12;
    localparam int RECT_W  = 12;
    localparam int SCR_W   = 13;
    localparam int PITCH_W = 16;
    localparam int SCALE_W = 5;
    localparam int POS_W   = 13;
    localparam int OFS_W   = 28;
    localparam int COLA_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_SCALE_DEF   = 16;
    localparam int BYTES_PER_PIXEL = 3;

    // reset values
    localparam logic [SCR_W-1:0]   SCREEN_W_RST = 13'd640;
    localparam logic [SCR_W-1:0]   SCREEN_H_RST = 13'd480;
    localparam logic [PITCH_W-1:0] PITCH_RST    = 16'd1920;
    localparam logic [SCALE_W-1:0] SCALE_RST    = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_RECT_WIDTH    = 3'd2,
        CFG_RECT_HEIGHT   = 3'd3,
        CFG_SCREEN_WIDTH  = 3'd4,
        CFG_SCREEN_HEIGHT = 3'd5,
        CFG_LINE_PITCH    = 3'd6,
        CFG_SCALE         = 3'd7
    } t_cfg_index;

    // walker step unit request / response
    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] cols;
        logic [POS_W-1:0] rows;
    } t_walk_in;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             wrap;   // column ran off the clip, moved to next row
        logic             ovf;    // row now at or past the clipped height
    } t_walk_out;

endpackage

@@ design/csrpw_step.sv @@
module csrpw_step (
    input  csrpw_pkg::t_walk_in  i_walk,
    output csrpw_pkg::t_walk_out o_walk
);

    logic                         wrap;
    logic [csrpw_pkg::POS_W-1:0]  row_nxt;

    assign wrap    = (i_walk.col >= i_walk.cols);
    assign row_nxt = wrap ? (i_walk.row + csrpw_pkg::POS_W'(1)) : i_walk.row;

    assign o_walk.wrap = wrap;
    assign o_walk.col  = wrap ? '0 : i_walk.col;
    assign o_walk.row  = row_nxt;
    assign o_walk.ovf  = (row_nxt >= i_walk.rows);

endmodule

@@ design/clipped_scaled_rect_pixel_writer.sv @@
// Clipped, horizontally scaled rectangle pixel writer.
//
// Slave stream: one 24-bit source pixel per word. Master stream: framebuffer
// writes, each a byte offset of the blue byte (green +1, red +2) plus the
// color, tlast on the final write caused by one input word and tuser on the
// final write of the clipped rectangle. The config port writes the geometry
// registers; write them only while the block is idle.
//
// The scale clamp happens on the accepting edge; then the setup states GEOM,
// CLIP, PREP and ADDR (the two products, clip bounds, stale-position fixup,
// address seeding) and one write per cycle while the receiver takes them,
// scale writes at most, all sequenced around one shared walker step unit.
// A new word is taken only back in idle, as s_tready is high only in idle.
// An empty clip gives no writes and returns to idle from ST_CLIP.
//
// A stalled receiver holds the output register; the walker waits until the
// word is taken. The next input word may be accepted while the last write of
// the previous one still sits in the output register.
// Reset (synchronous, active low) restores the register defaults, rewinds the
// walker and drops any pending write.
module clipped_scaled_rect_pixel_writer #(
    parameter int MAX_SCALE = csrpw_pkg::MAX_SCALE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config
    input  logic                             i_cfg_we,
    input  logic [csrpw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [csrpw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // source pixels
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [23:0]                      i_s_tdata,  // red[7:0] green[15:8] blue[23:16]
    // framebuffer writes
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [55:0]                      o_m_tdata,  // byte_offset[27:0] red[35:28]
                                                         // green[43:36] blue[51:44] zero[55:52]
    output logic                             o_m_tlast,  // last write of this input word
    output logic                             o_m_tuser   // region done
);

    localparam int REPS_W = $clog2(MAX_SCALE + 1);
    localparam int WP_W   = csrpw_pkg::RECT_W + REPS_W;
    localparam int XW     = WP_W + 1;
    localparam int POS_W  = csrpw_pkg::POS_W;
    localparam int OFS_W  = csrpw_pkg::OFS_W;
    localparam int COLA_W = csrpw_pkg::COLA_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_GEOM, ST_CLIP, ST_PREP, ST_ADDR, ST_EMIT
    } t_state;

    t_state r_state, n_state;

    // config registers
    logic [csrpw_pkg::ORG_W-1:0]   r_origin_x, n_origin_x;
    logic [csrpw_pkg::ORG_W-1:0]   r_origin_y, n_origin_y;
    logic [csrpw_pkg::RECT_W-1:0]  r_rect_width, n_rect_width;
    logic [csrpw_pkg::RECT_W-1:0]  r_rect_height, n_rect_height;
    logic [csrpw_pkg::SCR_W-1:0]   r_screen_width, n_screen_width;
    logic [csrpw_pkg::SCR_W-1:0]   r_screen_height, n_screen_height;
    logic [csrpw_pkg::PITCH_W-1:0] r_line_pitch, n_line_pitch;
    logic [csrpw_pkg::SCALE_W-1:0] r_scale, n_scale;

    // walker state, persists across words
    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic [OFS_W-1:0] r_row_base, n_row_base;

    // per-word working registers
    logic [7:0]        r_red, n_red, r_green, n_green, r_blue, n_blue;
    logic [REPS_W-1:0] r_reps, n_reps;
    logic [REPS_W-1:0] r_left, n_left;
    logic [WP_W-1:0]   r_wprod, n_wprod;
    logic [OFS_W-1:0]  r_top, n_top;
    logic [POS_W-1:0]  r_cols, n_cols;
    logic [POS_W-1:0]  r_rows, n_rows;
    logic [OFS_W-1:0]  r_row_addr, n_row_addr;
    logic [COLA_W-1:0] r_col_addr, n_col_addr;
    logic [COLA_W-1:0] r_col_base, n_col_base;

    // output register
    logic              r_m_valid, n_m_valid;
    logic [OFS_W-1:0]  r_m_ofs, n_m_ofs;
    logic [7:0]        r_m_red, n_m_red, r_m_green, n_m_green, r_m_blue, n_m_blue;
    logic              r_m_last, n_m_last;
    logic              r_m_done, n_m_done;

    // combinational helpers
    logic                  out_free;
    logic [XW-1:0]         end_x, lim_x;
    logic [POS_W-1:0]      end_y;
    logic [POS_W:0]        col_sum;
    csrpw_pkg::t_walk_in   walk_in;
    csrpw_pkg::t_walk_out  walk_out;

    // shared walker step unit: stale fixup in PREP, advance in EMIT
    assign walk_in.col  = (r_state == ST_EMIT) ? (r_col + POS_W'(1)) : r_col;
    assign walk_in.row  = r_row;
    assign walk_in.cols = r_cols;
    assign walk_in.rows = r_rows;

    csrpw_step u_step (
        .i_walk (walk_in),
        .o_walk (walk_out)
    );

    assign out_free = !r_m_valid || i_m_tready;
    assign end_x    = XW'(r_origin_x) + XW'(r_wprod);
    assign lim_x    = (end_x > XW'(r_screen_width)) ? XW'(r_screen_width) : end_x;
    assign end_y    = POS_W'(r_origin_y) + POS_W'(r_rect_height);
    assign col_sum  = (POS_W + 1)'(r_origin_x) + (POS_W + 1)'(r_col);

    always_comb begin
        n_state         = r_state;
        n_origin_x      = r_origin_x;
        n_origin_y      = r_origin_y;
        n_rect_width    = r_rect_width;
        n_rect_height   = r_rect_height;
        n_screen_width  = r_screen_width;
        n_screen_height = r_screen_height;
        n_line_pitch    = r_line_pitch;
        n_scale         = r_scale;
        n_col           = r_col;
        n_row           = r_row;
        n_row_base      = r_row_base;
        n_red           = r_red;
        n_green         = r_green;
        n_blue          = r_blue;
        n_reps          = r_reps;
        n_left          = r_left;
        n_wprod         = r_wprod;
        n_top           = r_top;
        n_cols          = r_cols;
        n_rows          = r_rows;
        n_row_addr      = r_row_addr;
        n_col_addr      = r_col_addr;
        n_col_base      = r_col_base;
        n_m_valid       = r_m_valid && !i_m_tready;
        n_m_ofs         = r_m_ofs;
        n_m_red         = r_m_red;
        n_m_green       = r_m_green;
        n_m_blue        = r_m_blue;
        n_m_last        = r_m_last;
        n_m_done        = r_m_done;

        if (i_cfg_we) begin
            unique case (csrpw_pkg::t_cfg_index'(i_cfg_index))
                csrpw_pkg::CFG_ORIGIN_X:      n_origin_x      = i_cfg_data[11:0];
                csrpw_pkg::CFG_ORIGIN_Y:      n_origin_y      = i_cfg_data[11:0];
                csrpw_pkg::CFG_RECT_WIDTH:    n_rect_width    = i_cfg_data[11:0];
                csrpw_pkg::CFG_RECT_HEIGHT:   n_rect_height   = i_cfg_data[11:0];
                csrpw_pkg::CFG_SCREEN_WIDTH:  n_screen_width  = i_cfg_data[12:0];
                csrpw_pkg::CFG_SCREEN_HEIGHT: n_screen_height = i_cfg_data[12:0];
                csrpw_pkg::CFG_LINE_PITCH:    n_line_pitch    = i_cfg_data;
                csrpw_pkg::CFG_SCALE:         n_scale         = i_cfg_data[4:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_red   = i_s_tdata[7:0];
                    n_green = i_s_tdata[15:8];
                    n_blue  = i_s_tdata[23:16];
                    // scale 0 acts as 1, above the max it saturates
                    priority if (r_scale == '0) begin
                        n_reps = REPS_W'(1);
                    end else if (32'(r_scale) > MAX_SCALE) begin
                        n_reps = REPS_W'(MAX_SCALE);
                    end else begin
                        n_reps = REPS_W'(r_scale);
                    end
                    n_state = ST_GEOM;
                end
            end
            ST_GEOM: begin
                n_wprod = WP_W'(r_rect_width) * WP_W'(r_reps);
                n_top   = OFS_W'(r_origin_y) * OFS_W'(r_line_pitch);
                n_state = ST_CLIP;
            end
            ST_CLIP: begin
                n_cols = POS_W'(lim_x - XW'(r_origin_x));
                n_rows = ((end_y > r_screen_height) ? r_screen_height : end_y)
                         - POS_W'(r_origin_y);
                if (XW'(r_screen_width) <= XW'(r_origin_x) ||
                    r_screen_height <= POS_W'(r_origin_y) || r_wprod == '0 ||
                    r_rect_height == '0) begin
                    // nothing on screen
                    n_col      = '0;
                    n_row      = '0;
                    n_row_base = '0;
                    n_state    = ST_IDLE;
                end else begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                // position may be stale after a geometry change
                if (walk_out.ovf) begin
                    n_col      = '0;
                    n_row      = '0;
                    n_row_base = '0;
                    n_state    = ST_IDLE;
                end else begin
                    n_col = walk_out.col;
                    n_row = walk_out.row;
                    if (walk_out.wrap) begin
                        n_row_base = r_row_base + OFS_W'(r_line_pitch);
                    end
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_row_addr = r_top + r_row_base;
                n_col_addr = COLA_W'(col_sum) * COLA_W'(csrpw_pkg::BYTES_PER_PIXEL);
                n_col_base = COLA_W'(r_origin_x) * COLA_W'(csrpw_pkg::BYTES_PER_PIXEL);
                n_left     = r_reps;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_ofs   = r_row_addr + OFS_W'(r_col_addr);
                    n_m_red   = r_red;
                    n_m_green = r_green;
                    n_m_blue  = r_blue;
                    n_m_done  = walk_out.wrap && walk_out.ovf;
                    n_m_last  = (walk_out.wrap && walk_out.ovf) || (r_left == REPS_W'(1));
                    n_left    = r_left - REPS_W'(1);
                    if (walk_out.wrap) begin
                        n_col      = '0;
                        n_row      = walk_out.row;
                        n_row_base = r_row_base + OFS_W'(r_line_pitch);
                        n_row_addr = r_row_addr + OFS_W'(r_line_pitch);
                        n_col_addr = r_col_base;
                    end else begin
                        n_col      = walk_out.col;
                        n_col_addr = r_col_addr + COLA_W'(csrpw_pkg::BYTES_PER_PIXEL);
                    end
                    if (walk_out.wrap && walk_out.ovf) begin
                        // region finished: rewind, drop remaining repeats
                        n_col      = '0;
                        n_row      = '0;
                        n_row_base = '0;
                    end
                    if (n_m_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_rect_width    <= '0;
            r_rect_height   <= '0;
            r_screen_width  <= csrpw_pkg::SCREEN_W_RST;
            r_screen_height <= csrpw_pkg::SCREEN_H_RST;
            r_line_pitch    <= csrpw_pkg::PITCH_RST;
            r_scale         <= csrpw_pkg::SCALE_RST;
            r_col           <= '0;
            r_row           <= '0;
            r_row_base      <= '0;
            r_left          <= '0;
            r_m_valid       <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_origin_x      <= n_origin_x;
            r_origin_y      <= n_origin_y;
            r_rect_width    <= n_rect_width;
            r_rect_height   <= n_rect_height;
            r_screen_width  <= n_screen_width;
            r_screen_height <= n_screen_height;
            r_line_pitch    <= n_line_pitch;
            r_scale         <= n_scale;
            r_col           <= n_col;
            r_row           <= n_row;
            r_row_base      <= n_row_base;
            r_left          <= n_left;
            r_m_valid       <= n_m_valid;
        end
        r_red      <= n_red;
        r_green    <= n_green;
        r_blue     <= n_blue;
        r_reps     <= n_reps;
        r_wprod    <= n_wprod;
        r_top      <= n_top;
        r_cols     <= n_cols;
        r_rows     <= n_rows;
        r_row_addr <= n_row_addr;
        r_col_addr <= n_col_addr;
        r_col_base <= n_col_base;
        r_m_ofs    <= n_m_ofs;
        r_m_red    <= n_m_red;
        r_m_green  <= n_m_green;
        r_m_blue   <= n_m_blue;
        r_m_last   <= n_m_last;
        r_m_done   <= n_m_done;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'b0000, r_m_blue, r_m_green, r_m_red, r_m_ofs};
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_done;

    // region end always closes the word's run
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tuser || o_m_tlast))
        else $error("region_done without last_of_item");

    // one word at a time: an accepted word blocks the next cycle
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted twice in a row");

    // walker column stays inside the clip while writing
    a_col_in_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_col < r_cols))
        else $error("walker column outside clip");

    // repeat counter never runs dry while writing
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_left != '0))
        else $error("repeat count exhausted in write phase");

endmodule

@@ bench/clipped_scaled_rect_pixel_writer_test.sv @@
`timescale 1ns / 1ps

module clipped_scaled_rect_pixel_writer_test;

    localparam int SETTLE_CYCLES = 32;     // setup steps + up to 16 writes + margin
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_WORDS  = 315;

    // one framebuffer write as seen on the master stream
    typedef struct packed {
        logic [csrpw_pkg::OFS_W-1:0] byte_offset;
        logic [7:0]                  red;
        logic [7:0]                  green;
        logic [7:0]                  blue;
        logic                        last_of_item;
        logic                        region_done;
    } t_fb_write;

    logic clk;
    logic rst_n = 1'b0;

    logic                             cfg_we    = 1'b0;
    csrpw_pkg::t_cfg_index            cfg_index = csrpw_pkg::CFG_ORIGIN_X;
    logic [csrpw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    clipped_scaled_rect_pixel_writer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),     // red[7:0] green[15:8] blue[23:16]
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),     // byte_offset[27:0] red[35:28] green[43:36]
                                    // blue[51:44] zero[55:52]
        .o_m_tlast   (m_tlast),     // last write of the input word
        .o_m_tuser   (m_tuser)      // region done
    );

    // ------------------------------------------------------------------
    // Shadow of the geometry registers and of the walker position
    // ------------------------------------------------------------------
    logic [csrpw_pkg::ORG_W-1:0]   reg_origin_x      = '0;
    logic [csrpw_pkg::ORG_W-1:0]   reg_origin_y      = '0;
    logic [csrpw_pkg::RECT_W-1:0]  reg_rect_width    = '0;
    logic [csrpw_pkg::RECT_W-1:0]  reg_rect_height   = '0;
    logic [csrpw_pkg::SCR_W-1:0]   reg_screen_width  = csrpw_pkg::SCREEN_W_RST;
    logic [csrpw_pkg::SCR_W-1:0]   reg_screen_height = csrpw_pkg::SCREEN_H_RST;
    logic [csrpw_pkg::PITCH_W-1:0] reg_line_pitch    = csrpw_pkg::PITCH_RST;
    logic [csrpw_pkg::SCALE_W-1:0] reg_scale         = csrpw_pkg::SCALE_RST;

    logic [csrpw_pkg::POS_W-1:0] walk_col     = '0;   // relative to origin_x
    logic [csrpw_pkg::POS_W-1:0] walk_row     = '0;   // relative to origin_y
    logic [28:0]                 walk_row_ofs = '0;   // walk_row * line_pitch, 29-bit wrap

    logic [23:0] pixel_queue[$];       // source words not yet presented
    t_fb_write   pending_writes[$];    // predicted writes, oldest first

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    // per-phase idling: none, sender gaps, receiver stalls, both
    int unsigned send_idle_by_phase[4]  = '{0, 51, 0, 18};
    int unsigned recv_stall_by_phase[4] = '{0, 0, 51, 18};

    t_fb_write seen_write;
    t_fb_write want_write;

    // in-clip positions along one axis
    function automatic int unsigned clip_span(input int unsigned start,
                                              input int unsigned length,
                                              input int unsigned limit);
        int unsigned stop;
        if (limit <= start)
            return 0;
        stop = start + length;
        if (stop > limit)
            stop = limit;
        return stop - start;
    endfunction

    function automatic void rewind_walker();
        walk_col     = '0;
        walk_row     = '0;
        walk_row_ofs = '0;
    endfunction

    function automatic void step_to_next_row();
        walk_col     = '0;
        walk_row     = walk_row + 1'b1;
        walk_row_ofs = walk_row_ofs + reg_line_pitch;
    endfunction

    // Walks the clipped rectangle for one source word and queues its writes.
    // The last write is held back one step so tlast can be set on it.
    function automatic void predict_writes(input logic [23:0] word);
        int unsigned reps;
        int unsigned cols;
        int unsigned rows;
        int unsigned top_ofs;
        int unsigned addr;
        int          k;
        t_fb_write   held;
        bit          have_held;
        have_held = 1'b0;
        held      = '0;
        reps = reg_scale;
        // scale 0 behaves as 1, anything past the max clamps
        if (reps < 1)
            reps = 1;
        if (reps > csrpw_pkg::MAX_SCALE_DEF)
            reps = csrpw_pkg::MAX_SCALE_DEF;
        cols = clip_span(reg_origin_x, reg_rect_width * reps, reg_screen_width);
        rows = clip_span(reg_origin_y, reg_rect_height, reg_screen_height);
        // nothing visible: no writes, walker back to the top left
        if (cols == 0 || rows == 0) begin
            rewind_walker();
            return;
        end
        top_ofs = reg_origin_y * reg_line_pitch;
        for (k = 0; k < reps; k++) begin
            // stale column after a geometry change: move down a row
            if (walk_col >= cols)
                step_to_next_row();
            // stale row: rewind and drop the rest of the word, no region_done
            if (walk_row >= rows) begin
                rewind_walker();
                break;
            end
            if (have_held)
                pending_writes.push_back(held);
            addr = top_ofs + walk_row_ofs
                   + (reg_origin_x + walk_col) * csrpw_pkg::BYTES_PER_PIXEL;
            held.byte_offset  = addr[csrpw_pkg::OFS_W-1:0];   // wraps modulo 2^28
            held.red          = word[7:0];
            held.green        = word[15:8];
            held.blue         = word[23:16];
            held.last_of_item = 1'b0;
            held.region_done  = 1'b0;
            have_held         = 1'b1;
            walk_col = walk_col + 1'b1;
            if (walk_col >= cols) begin
                step_to_next_row();
                // region ends mid-word: remaining repeats are dropped
                if (walk_row >= rows) begin
                    held.region_done = 1'b1;
                    rewind_walker();
                    break;
                end
            end
        end
        if (have_held) begin
            held.last_of_item = 1'b1;
            pending_writes.push_back(held);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout: %0d writes still expected", pending_writes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Source driver: presents queued words, random gaps between them.
    // A word is predicted on the edge it is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_writes(s_tdata);
            // slot is free unless a word is stuck waiting for tready
            if (!s_tvalid || s_tready) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Write monitor: compares each accepted write with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_write.byte_offset  = m_tdata[27:0];
                seen_write.red          = m_tdata[35:28];
                seen_write.green        = m_tdata[43:36];
                seen_write.blue         = m_tdata[51:44];
                seen_write.last_of_item = m_tlast;
                seen_write.region_done  = m_tuser;
                if (pending_writes.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected write: ofs=%h rgb=%h%h%h last=%b done=%b",
                                 seen_write.byte_offset, seen_write.red, seen_write.green,
                                 seen_write.blue, seen_write.last_of_item,
                                 seen_write.region_done);
                end else begin
                    want_write = pending_writes.pop_front();
                    if (seen_write !== want_write) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("write mismatch: expected ofs=%h rgb=%h%h%h last=%b done=%b",
                                     want_write.byte_offset, want_write.red,
                                     want_write.green, want_write.blue,
                                     want_write.last_of_item, want_write.region_done);
                            $display("                got      ofs=%h rgb=%h%h%h last=%b done=%b",
                                     seen_write.byte_offset, seen_write.red,
                                     seen_write.green, seen_write.blue,
                                     seen_write.last_of_item, seen_write.region_done);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // one register write, shadow updated on the same edge
    task automatic write_reg(input csrpw_pkg::t_cfg_index idx,
                             input logic [csrpw_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            csrpw_pkg::CFG_ORIGIN_X:      reg_origin_x      = value[csrpw_pkg::ORG_W-1:0];
            csrpw_pkg::CFG_ORIGIN_Y:      reg_origin_y      = value[csrpw_pkg::ORG_W-1:0];
            csrpw_pkg::CFG_RECT_WIDTH:    reg_rect_width    = value[csrpw_pkg::RECT_W-1:0];
            csrpw_pkg::CFG_RECT_HEIGHT:   reg_rect_height   = value[csrpw_pkg::RECT_W-1:0];
            csrpw_pkg::CFG_SCREEN_WIDTH:  reg_screen_width  = value[csrpw_pkg::SCR_W-1:0];
            csrpw_pkg::CFG_SCREEN_HEIGHT: reg_screen_height = value[csrpw_pkg::SCR_W-1:0];
            csrpw_pkg::CFG_LINE_PITCH:    reg_line_pitch    = value[csrpw_pkg::PITCH_W-1:0];
            csrpw_pkg::CFG_SCALE:         reg_scale         = value[csrpw_pkg::SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // drain everything, then give a word with no writes time to finish;
    // sampled away from the rising edge so the driver's updates have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || s_tvalid || pending_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly near the top left so small screens still clip against it
    function automatic logic [csrpw_pkg::CFG_DATA_W-1:0] pick_origin();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'd4095;
            2, 3, 4: return 16'($urandom_range(4095));
            default: return 16'($urandom_range(24));
        endcase
    endfunction

    // small rectangles so region_done comes often; the odd huge or empty one
    function automatic logic [csrpw_pkg::CFG_DATA_W-1:0] pick_extent(
        input int unsigned small_max);
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'd4095;
            2:       return 16'($urandom_range(4095));
            default: return 16'($urandom_range(1, small_max));
        endcase
    endfunction

    function automatic logic [csrpw_pkg::CFG_DATA_W-1:0] pick_screen();
        case ($urandom_range(9))
            0:       return 16'd0;
            1, 2:    return 16'd4096;
            3, 4:    return 16'($urandom_range(4096));
            default: return 16'($urandom_range(1, 48));
        endcase
    endfunction

    // rewrites a random subset so the walker often sees a stale position
    task automatic randomize_geometry();
        if ($urandom_range(1))
            write_reg(csrpw_pkg::CFG_ORIGIN_X, pick_origin());
        if ($urandom_range(1))
            write_reg(csrpw_pkg::CFG_ORIGIN_Y, pick_origin());
        if ($urandom_range(1))
            write_reg(csrpw_pkg::CFG_RECT_WIDTH, pick_extent(6));
        if ($urandom_range(1))
            write_reg(csrpw_pkg::CFG_RECT_HEIGHT, pick_extent(5));
        if ($urandom_range(1))
            write_reg(csrpw_pkg::CFG_SCREEN_WIDTH, pick_screen());
        if ($urandom_range(1))
            write_reg(csrpw_pkg::CFG_SCREEN_HEIGHT, pick_screen());
        if ($urandom_range(1))
            write_reg(csrpw_pkg::CFG_LINE_PITCH, ($urandom_range(3) == 0) ?
                      16'($urandom_range(1) ? 65535 : 0) : 16'($urandom));
        if ($urandom_range(1))
            write_reg(csrpw_pkg::CFG_SCALE, ($urandom_range(3) == 0) ?
                      16'($urandom_range(31)) : 16'($urandom_range(1, 16)));
    endtask

    initial begin
        int unsigned phase;
        int unsigned burst;
        int unsigned random_words;
        phase        = 0;
        random_words = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, no idling ---

        // reset geometry has a zero-size rectangle: no writes at all
        pixel_queue.push_back(24'h000000);
        wait_idle();

        // bottom-right screen corner, 2x2 visible, scale 3: region ends
        // mid-word, the next word restarts its repeat count
        write_reg(csrpw_pkg::CFG_ORIGIN_X, 16'd638);
        write_reg(csrpw_pkg::CFG_ORIGIN_Y, 16'd478);
        write_reg(csrpw_pkg::CFG_RECT_WIDTH, 16'd2);
        write_reg(csrpw_pkg::CFG_RECT_HEIGHT, 16'd3);
        write_reg(csrpw_pkg::CFG_SCALE, 16'd3);
        pixel_queue.push_back(24'hFFFFFF);
        pixel_queue.push_back(24'hFF00FF);
        pixel_queue.push_back(24'h00FF00);
        wait_idle();

        // far corner of a full-size screen with max pitch: offset near the top of its 28-bit range
        write_reg(csrpw_pkg::CFG_ORIGIN_X, 16'd4095);
        write_reg(csrpw_pkg::CFG_ORIGIN_Y, 16'd4095);
        write_reg(csrpw_pkg::CFG_RECT_WIDTH, 16'd1);
        write_reg(csrpw_pkg::CFG_RECT_HEIGHT, 16'd1);
        write_reg(csrpw_pkg::CFG_SCREEN_WIDTH, 16'd4096);
        write_reg(csrpw_pkg::CFG_SCREEN_HEIGHT, 16'd4096);
        write_reg(csrpw_pkg::CFG_LINE_PITCH, 16'd65535);
        write_reg(csrpw_pkg::CFG_SCALE, 16'd16);
        pixel_queue.push_back(24'hA5A5A5);
        pixel_queue.push_back(24'h5A5A5A);
        wait_idle();

        // scale 0 acts as 1, zero pitch
        write_reg(csrpw_pkg::CFG_ORIGIN_X, 16'd0);
        write_reg(csrpw_pkg::CFG_ORIGIN_Y, 16'd0);
        write_reg(csrpw_pkg::CFG_RECT_WIDTH, 16'd4);
        write_reg(csrpw_pkg::CFG_RECT_HEIGHT, 16'd2);
        write_reg(csrpw_pkg::CFG_LINE_PITCH, 16'd0);
        write_reg(csrpw_pkg::CFG_SCALE, 16'd0);
        pixel_queue.push_back(24'h123456);
        pixel_queue.push_back(24'h654321);
        wait_idle();

        // scale past the max clamps to 16 writes per word
        write_reg(csrpw_pkg::CFG_SCALE, 16'd31);
        pixel_queue.push_back(24'h0F0F0F);
        pixel_queue.push_back(24'hF0F0F0);
        wait_idle();

        // stale position: narrow the rectangle under the walker, then make
        // it one row high; the walker has rewound, so each word ends the region
        write_reg(csrpw_pkg::CFG_LINE_PITCH, 16'd1920);
        write_reg(csrpw_pkg::CFG_SCALE, 16'd1);
        write_reg(csrpw_pkg::CFG_RECT_HEIGHT, 16'd3);
        pixel_queue.push_back(24'h010203);
        pixel_queue.push_back(24'h040506);
        wait_idle();
        write_reg(csrpw_pkg::CFG_RECT_WIDTH, 16'd1);
        pixel_queue.push_back(24'h070809);
        wait_idle();
        write_reg(csrpw_pkg::CFG_RECT_HEIGHT, 16'd1);
        pixel_queue.push_back(24'h0A0B0C);
        pixel_queue.push_back(24'h0D0E0F);
        wait_idle();

        // rectangle fully off a zero-size screen, each axis in turn
        write_reg(csrpw_pkg::CFG_SCREEN_WIDTH, 16'd0);
        pixel_queue.push_back(24'hC3C3C3);
        wait_idle();
        write_reg(csrpw_pkg::CFG_SCREEN_WIDTH, 16'd4096);
        write_reg(csrpw_pkg::CFG_SCREEN_HEIGHT, 16'd0);
        pixel_queue.push_back(24'h3C3C3C);
        wait_idle();

        // --- random part: geometry per phase, idling rotates ---
        while (random_words < RANDOM_WORDS) begin
            randomize_geometry();
            send_idle_pct  = send_idle_by_phase[phase % 4];
            recv_stall_pct = recv_stall_by_phase[phase % 4];
            burst = $urandom_range(6, 30);
            repeat (burst)
                pixel_queue.push_back(24'($urandom));
            random_words += burst;
            wait_idle();
            phase++;
        end

        if (error_count == 0 && pending_writes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
